/* design/sa_pkg.sv */
// ----------------------------------------------------------------------------
// sa_pkg
// Shared constants, sequencer codes and control structs for the suffix
// automaton builder.
// ----------------------------------------------------------------------------
package sa_pkg;

  localparam int MAX_TEXT = 4096;
  localparam int ALPHABET = 26;
  localparam int NODES    = 2 * MAX_TEXT;

  localparam int NODE_W   = $clog2(NODES);
  localparam int TOTAL_W  = NODE_W + 1;
  localparam int TEXT_W   = $clog2(MAX_TEXT + 1);
  localparam int SYM_W    = 5;
  localparam int TADDR_W  = NODE_W + SYM_W;
  localparam int CNT_W    = SYM_W;

  // input actions
  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // sequencer states
  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE    = 5'd0;
  localparam logic [ST_W-1:0] ST_EMIT    = 5'd1;
  localparam logic [ST_W-1:0] ST_CLR     = 5'd2;
  localparam logic [ST_W-1:0] ST_Q_RD    = 5'd3;
  localparam logic [ST_W-1:0] ST_Q_CHK   = 5'd4;
  localparam logic [ST_W-1:0] ST_A_LEN   = 5'd5;
  localparam logic [ST_W-1:0] ST_A_INIT  = 5'd6;
  localparam logic [ST_W-1:0] ST_A_ZERO  = 5'd7;
  localparam logic [ST_W-1:0] ST_W_RD    = 5'd8;
  localparam logic [ST_W-1:0] ST_W_CHK   = 5'd9;
  localparam logic [ST_W-1:0] ST_P_LEN   = 5'd10;
  localparam logic [ST_W-1:0] ST_U_LEN   = 5'd11;
  localparam logic [ST_W-1:0] ST_CL_LINK = 5'd12;
  localparam logic [ST_W-1:0] ST_CP_RD   = 5'd13;
  localparam logic [ST_W-1:0] ST_CP_WR   = 5'd14;
  localparam logic [ST_W-1:0] ST_R_RD    = 5'd15;
  localparam logic [ST_W-1:0] ST_R_CHK   = 5'd16;
  localparam logic [ST_W-1:0] ST_FIX1    = 5'd17;
  localparam logic [ST_W-1:0] ST_FIX2    = 5'd18;

  typedef struct packed {
    logic [ST_W-1:0] op;
    logic            capture;
    logic            emit;
    logic            fin_app;
  } sa_cmd_t;

  typedef struct packed {
    logic app_ok;
    logic trans_zero;
    logic u_zero;
    logic len_eq;
    logic hit;
    logic cnt_last;
  } sa_stat_t;

endpackage

/* design/sa_ram.sv */
// ----------------------------------------------------------------------------
// sa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sa_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/sa_ctrl.sv */
// ----------------------------------------------------------------------------
// sa_ctrl
// Sequencer for append, query and clear; drives datapath commands.
// ----------------------------------------------------------------------------
module sa_ctrl import sa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic [1:0] in_action,
  input  sa_stat_t stat,
  output sa_cmd_t  cmd,
  output logic     busy
);

  logic [ST_W-1:0] state_r, state_nxt;
  logic            quiet_r, quiet_nxt;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    quiet_nxt   = quiet_r;
    cmd.op      = state_r;
    cmd.capture = 1'b0;
    cmd.emit    = 1'b0;
    cmd.fin_app = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          case (in_action)
            ACT_APPEND: state_nxt = stat.app_ok ? ST_A_LEN : ST_EMIT;
            ACT_QUERY:  state_nxt = ST_Q_RD;
            ACT_CLEAR:  state_nxt = ST_CLR;
            default:    state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_CLR: begin
        if (stat.cnt_last) begin
          cmd.emit  = !quiet_r;
          quiet_nxt = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      ST_Q_RD:   state_nxt = ST_Q_CHK;
      ST_Q_CHK: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_A_LEN:  state_nxt = ST_A_INIT;
      ST_A_INIT: state_nxt = ST_A_ZERO;
      ST_A_ZERO: begin
        if (stat.cnt_last) state_nxt = ST_W_RD;
      end
      ST_W_RD:   state_nxt = ST_W_CHK;
      ST_W_CHK: begin
        if (stat.trans_zero && stat.u_zero) begin
          cmd.emit    = 1'b1;
          cmd.fin_app = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (stat.trans_zero) begin
          state_nxt = ST_W_RD;
        end else begin
          state_nxt = ST_P_LEN;
        end
      end
      ST_P_LEN:  state_nxt = ST_U_LEN;
      ST_U_LEN: begin
        if (stat.len_eq) begin
          cmd.emit    = 1'b1;
          cmd.fin_app = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          state_nxt = ST_CL_LINK;
        end
      end
      ST_CL_LINK: state_nxt = ST_CP_RD;
      ST_CP_RD:   state_nxt = ST_CP_WR;
      ST_CP_WR:   state_nxt = stat.cnt_last ? ST_R_RD : ST_CP_RD;
      ST_R_RD:    state_nxt = ST_R_CHK;
      ST_R_CHK:   state_nxt = (stat.hit && !stat.u_zero) ? ST_R_RD : ST_FIX1;
      ST_FIX1:    state_nxt = ST_FIX2;
      ST_FIX2: begin
        cmd.emit    = 1'b1;
        cmd.fin_app = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // state register; reset runs a silent clearing pass of the root row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      quiet_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      quiet_r <= quiet_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* design/sa_dpath.sv */
// ----------------------------------------------------------------------------
// sa_dpath
// Node pool memories, automaton registers and result registers.
// ----------------------------------------------------------------------------
module sa_dpath import sa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  sa_cmd_t           cmd,
  input  logic [1:0]        in_action,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic              in_pattern_end,
  output sa_stat_t          stat,
  output logic              out_valid,
  output logic              out_found,
  output logic [12:0]       out_matched_length,
  output logic [12:0]       out_state_count,
  output logic              out_overflow
);

  // memory ports
  logic               tr_we;
  logic [TADDR_W-1:0] tr_wa, tr_ra;
  logic [NODE_W-1:0]  tr_wd, tr_rd;
  logic               ln_we, lk_we;
  logic [NODE_W-1:0]  ln_wa, ln_ra, ln_wd, ln_rd;
  logic [NODE_W-1:0]  lk_wa, lk_ra, lk_wd, lk_rd;

  // registers
  logic [NODE_W-1:0]  last_r, last_nxt, cur_r, cur_nxt, u_r, u_nxt;
  logic [NODE_W-1:0]  p_r, p_nxt, cl_r, cl_nxt, lenp_r, lenp_nxt;
  logic [NODE_W-1:0]  qcur_r, qcur_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TEXT_W-1:0]  text_r, text_nxt;
  logic [12:0]        qcnt_r, qcnt_nxt;
  logic               alive_r, alive_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic               pend_r, pend_nxt, ovf_r, ovf_nxt;
  logic               ov_r, ov_nxt, of_r, of_nxt;
  logic [12:0]        om_r, om_nxt, os_r, os_nxt;
  logic               found_v;
  logic [12:0]        match_v, qstep;
  logic               astep;
  logic [NODE_W-1:0]  qn;

  sa_ram #(.WIDTH(NODE_W), .DEPTH(2 ** TADDR_W)) u_trans (
    .clk(clk), .we(tr_we), .waddr(tr_wa), .wdata(tr_wd), .raddr(tr_ra), .rdata(tr_rd)
  );
  sa_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_len (
    .clk(clk), .we(ln_we), .waddr(ln_wa), .wdata(ln_wd), .raddr(ln_ra), .rdata(ln_rd)
  );
  sa_ram #(.WIDTH(NODE_W), .DEPTH(NODES)) u_link (
    .clk(clk), .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd)
  );

  // status towards the sequencer
  always_comb begin
    stat.app_ok = (text_r < TEXT_W'(MAX_TEXT)) && (in_symbol < SYM_W'(ALPHABET))
                  && ({1'b0, total_r} + (TOTAL_W+1)'(2) <= (TOTAL_W+1)'(NODES));
    stat.trans_zero = (tr_rd == '0);
    stat.u_zero     = (u_r == '0);
    stat.len_eq     = (lenp_r == ln_rd + NODE_W'(1));
    stat.hit        = (tr_rd == p_r);
    stat.cnt_last   = (cnt_r == CNT_W'(ALPHABET - 1));
  end

  // one step of the pattern walk
  always_comb begin
    qn    = (alive_r && (sym_r < SYM_W'(ALPHABET))) ? tr_rd : '0;
    astep = alive_r && (qn != '0);
    qstep = astep ? qcnt_r + 13'd1 : qcnt_r;
  end

  // datapath per sequencer step
  always_comb begin
    tr_we = 1'b0; tr_wa = '0; tr_wd = '0; tr_ra = {u_r, sym_r};
    ln_we = 1'b0; ln_wa = '0; ln_wd = '0; ln_ra = last_r;
    lk_we = 1'b0; lk_wa = '0; lk_wd = '0; lk_ra = u_r;
    last_nxt = last_r; cur_nxt = cur_r; u_nxt = u_r; p_nxt = p_r; cl_nxt = cl_r;
    lenp_nxt = lenp_r; qcur_nxt = qcur_r; total_nxt = total_r; text_nxt = text_r;
    qcnt_nxt = qcnt_r; alive_nxt = alive_r; cnt_nxt = cnt_r;
    sym_nxt = sym_r; pend_nxt = pend_r; ovf_nxt = ovf_r;
    found_v = 1'b0; match_v = qcnt_r;
    case (cmd.op)
      ST_IDLE: begin
        if (cmd.capture) begin
          sym_nxt  = in_symbol;
          pend_nxt = in_pattern_end;
          ovf_nxt  = (in_action == ACT_APPEND) && (text_r >= TEXT_W'(MAX_TEXT));
        end
      end
      ST_CLR: begin
        tr_we = 1'b1; tr_wa = {NODE_W'(0), cnt_r};
        ln_we = 1'b1; ln_wa = '0;
        lk_we = 1'b1; lk_wa = '0;
        last_nxt = '0; total_nxt = TOTAL_W'(1); text_nxt = '0;
        qcur_nxt = '0; alive_nxt = 1'b1; qcnt_nxt = '0;
        match_v = '0;
        cnt_nxt = stat.cnt_last ? '0 : cnt_r + CNT_W'(1);
      end
      ST_Q_RD: tr_ra = {qcur_r, sym_r};
      ST_Q_CHK: begin
        if (alive_r) begin
          if (qn == '0) alive_nxt = 1'b0;
          else qcur_nxt = qn;
        end
        match_v  = qstep;
        qcnt_nxt = qstep;
        if (pend_r) begin
          found_v   = astep || (alive_r && qn != '0);
          qcur_nxt  = '0;
          alive_nxt = 1'b1;
          qcnt_nxt  = '0;
        end
      end
      ST_A_INIT: begin
        ln_we = 1'b1; ln_wa = total_r[NODE_W-1:0]; ln_wd = ln_rd + NODE_W'(1);
        lk_we = 1'b1; lk_wa = total_r[NODE_W-1:0];
        cur_nxt   = total_r[NODE_W-1:0];
        u_nxt     = last_r;
        total_nxt = total_r + TOTAL_W'(1);
      end
      ST_A_ZERO: begin
        tr_we = 1'b1; tr_wa = {cur_r, cnt_r};
        cnt_nxt = stat.cnt_last ? '0 : cnt_r + CNT_W'(1);
      end
      ST_W_CHK: begin
        if (stat.trans_zero) begin
          tr_we = 1'b1; tr_wa = {u_r, sym_r}; tr_wd = cur_r;
          if (!stat.u_zero) u_nxt = lk_rd;
        end else begin
          p_nxt = tr_rd;
          ln_ra = tr_rd;
        end
      end
      ST_P_LEN: begin
        lenp_nxt = ln_rd;
        ln_ra    = u_r;
      end
      ST_U_LEN: begin
        lk_ra = p_r;
        if (stat.len_eq) begin
          lk_we = 1'b1; lk_wa = cur_r; lk_wd = p_r;
        end else begin
          ln_we = 1'b1; ln_wa = total_r[NODE_W-1:0]; ln_wd = ln_rd + NODE_W'(1);
          cl_nxt    = total_r[NODE_W-1:0];
          total_nxt = total_r + TOTAL_W'(1);
        end
      end
      ST_CL_LINK: begin
        lk_we = 1'b1; lk_wa = cl_r; lk_wd = lk_rd;
      end
      ST_CP_RD: tr_ra = {p_r, cnt_r};
      ST_CP_WR: begin
        tr_we = 1'b1; tr_wa = {cl_r, cnt_r}; tr_wd = tr_rd;
        cnt_nxt = stat.cnt_last ? '0 : cnt_r + CNT_W'(1);
      end
      ST_R_CHK: begin
        if (stat.hit) begin
          tr_we = 1'b1; tr_wa = {u_r, sym_r}; tr_wd = cl_r;
          if (!stat.u_zero) u_nxt = lk_rd;
        end
      end
      ST_FIX1: begin
        lk_we = 1'b1; lk_wa = p_r; lk_wd = cl_r;
      end
      ST_FIX2: begin
        lk_we = 1'b1; lk_wa = cur_r; lk_wd = cl_r;
      end
      default: begin
      end
    endcase
    // commit an append
    if (cmd.fin_app) begin
      last_nxt = cur_r;
      text_nxt = text_r + TEXT_W'(1);
    end
    // result fields
    ov_nxt = cmd.emit;
    of_nxt = found_v;
    om_nxt = match_v;
    os_nxt = total_nxt[12:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      total_r <= TOTAL_W'(1);
      text_r  <= '0;
      qcur_r  <= '0;
      alive_r <= 1'b1;
      qcnt_r  <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      last_r  <= last_nxt;
      total_r <= total_nxt;
      text_r  <= text_nxt;
      qcur_r  <= qcur_nxt;
      alive_r <= alive_nxt;
      qcnt_r  <= qcnt_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    u_r    <= u_nxt;
    p_r    <= p_nxt;
    cl_r   <= cl_nxt;
    lenp_r <= lenp_nxt;
    sym_r  <= sym_nxt;
    pend_r <= pend_nxt;
    ovf_r  <= ovf_nxt;
    if (cmd.emit) begin
      of_r <= of_nxt;
      om_r <= om_nxt;
      os_r <= os_nxt;
    end
  end

  assign out_valid          = ov_r;
  assign out_found          = of_r;
  assign out_matched_length = om_r;
  assign out_state_count    = os_r;
  assign out_overflow       = ovf_r;

endmodule

/* design/suffix_automaton_builder_unit.sv */
// ----------------------------------------------------------------------------
// suffix_automaton_builder_unit
// Online suffix automaton over a bounded node pool with substring queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input: present in_action, in_symbol and in_pattern_end with start; the
//   transfer takes place on a rising edge with start high and busy low.
//   Result: one result per input, shown for one cycle with out_valid high;
//   the receiver always takes it, there is no back-pressure.
// Work per input, on the node-pool memories:
//   a rejected append or unused action only emits its result; a query reads
//   one transition; clear writes the root row, one root-row entry a cycle;
//   an append walks suffix links until the first check reaches the root or
//   meets a solid transition, and clones a node otherwise (26 entries copied),
//   then takes a further suffix-link or redirect step while one is needed.
// Reset: the pool is set to the root alone; a pass clears the
//   root transition row with busy high, and gives no result.
// ----------------------------------------------------------------------------
module suffix_automaton_builder_unit import sa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_action,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic             in_pattern_end,
  output logic             out_valid,
  output logic             out_found,
  output logic [12:0]      out_matched_length,
  output logic [12:0]      out_state_count,
  output logic             out_overflow
);

  sa_cmd_t  cmd;
  sa_stat_t stat;

  sa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_action(in_action),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  sa_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_action(in_action),
    .in_symbol(in_symbol), .in_pattern_end(in_pattern_end), .stat(stat),
    .out_valid(out_valid), .out_found(out_found),
    .out_matched_length(out_matched_length), .out_state_count(out_state_count),
    .out_overflow(out_overflow)
  );

`ifndef SYNTHESIS
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while sequencer busy");
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("transfer did not start work");
  a_count_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_state_count != 13'd0)) else $error("empty node pool");
  a_ovf_nofound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> !out_found) else $error("overflow with found");
`endif

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the suffix automaton builder. A queue of pending
// transfers drives the command port in random bursts; a local automaton
// predicts each result and a monitor compares every strobed result with it.
// ----------------------------------------------------------------------------
module tb_top;
  import sa_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]       action;
    logic [SYM_W-1:0] symbol;
    logic             pattern_end;
    bit               drain;
  } cmd_item_t;

  typedef struct {
    logic        found;
    logic [12:0] matched;
    logic [12:0] count;
    logic        overflow;
  } sa_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       in_action = ACT_APPEND;
  logic [SYM_W-1:0] in_symbol = '0;
  logic             in_pattern_end = 1'b0;
  logic             out_valid;
  logic             out_found;
  logic [12:0]      out_matched_length;
  logic [12:0]      out_state_count;
  logic             out_overflow;

  suffix_automaton_builder_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_symbol(in_symbol), .in_pattern_end(in_pattern_end),
    .out_valid(out_valid), .out_found(out_found),
    .out_matched_length(out_matched_length), .out_state_count(out_state_count),
    .out_overflow(out_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cmd_item_t  pending_cmds[$];
  sa_result_t expected_results[$];
  cmd_item_t  cur_cmd;
  int         error_count = 0;
  int         burst_left = 0;
  int         gap_left = 0;

  // local copy of the automaton
  int trans[NODES*ALPHABET];
  int slink[NODES];
  int nlen[NODES];
  int last_id, total, tlen, qcur, qalive, qcnt;

  function automatic int new_node(int len);
    int id;
    id = total;
    total++;
    for (int k = 0; k < ALPHABET; k++) trans[id*ALPHABET+k] = 0;
    nlen[id] = len;
    slink[id] = 0;
    return id;
  endfunction

  function automatic void reset_automaton();
    for (int k = 0; k < ALPHABET; k++) trans[k] = 0;
    slink[0] = 0; nlen[0] = 0;
    last_id = 0; total = 1; tlen = 0;
    qcur = 0; qalive = 1; qcnt = 0;
  endfunction

  function automatic void extend_automaton(int c);
    int cur, u, p, cl;
    bit walking;
    cur = new_node(nlen[last_id] + 1);
    u = last_id;
    walking = 1;
    while (walking && trans[u*ALPHABET+c] == 0) begin
      trans[u*ALPHABET+c] = cur;
      if (u == 0) walking = 0; else u = slink[u];
    end
    if (walking) begin
      p = trans[u*ALPHABET+c];
      if (nlen[p] == nlen[u] + 1) begin
        slink[cur] = p;
      end else begin
        cl = new_node(nlen[u] + 1);
        for (int k = 0; k < ALPHABET; k++) trans[cl*ALPHABET+k] = trans[p*ALPHABET+k];
        slink[cl] = slink[p];
        while (walking && trans[u*ALPHABET+c] == p) begin
          trans[u*ALPHABET+c] = cl;
          if (u == 0) walking = 0; else u = slink[u];
        end
        slink[p] = cl;
        slink[cur] = cl;
      end
    end
    last_id = cur;
    tlen++;
  endfunction

  function automatic sa_result_t predict_result(cmd_item_t c);
    sa_result_t r;
    int nxt;
    r.found = 1'b0;
    r.overflow = 1'b0;
    case (c.action)
      ACT_APPEND: begin
        if (tlen >= MAX_TEXT) r.overflow = 1'b1;
        else if (c.symbol < ALPHABET && total + 2 <= NODES) extend_automaton(c.symbol);
        r.matched = 13'(qcnt);
      end
      ACT_QUERY: begin
        if (qalive != 0) begin
          nxt = (c.symbol < ALPHABET) ? trans[qcur*ALPHABET+c.symbol] : 0;
          if (nxt == 0) qalive = 0;
          else begin
            qcur = nxt;
            qcnt++;
          end
        end
        r.matched = 13'(qcnt);
        if (c.pattern_end) begin
          r.found = (qalive != 0);
          qcur = 0; qalive = 1; qcnt = 0;
        end
      end
      ACT_CLEAR: begin
        reset_automaton();
        r.matched = '0;
      end
      default: r.matched = 13'(qcnt);
    endcase
    r.count = 13'(total);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // driver: hold a command until it transfers, then advance in bursts
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) expected_results.push_back(predict_result(cur_cmd));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_cmds.size() == 0) begin
          start <= 1'b0;
        end else if (pending_cmds[0].drain) begin
          start <= 1'b0;
          if (expected_results.size() == 0 && !(start && !busy) && !busy)
            void'(pending_cmds.pop_front());
        end else begin
          cur_cmd = pending_cmds.pop_front();
          start <= 1'b1;
          in_action <= cur_cmd.action;
          in_symbol <= cur_cmd.symbol;
          in_pattern_end <= cur_cmd.pattern_end;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // monitor: compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    sa_result_t w;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = expected_results.pop_front();
        if (out_found !== w.found) report_mismatch("found", out_found, w.found);
        if (out_matched_length !== w.matched)
          report_mismatch("matched_length", out_matched_length, w.matched);
        if (out_state_count !== w.count)
          report_mismatch("state_count", out_state_count, w.count);
        if (out_overflow !== w.overflow) report_mismatch("overflow", out_overflow, w.overflow);
      end
    end
  end

  function automatic void add_cmd(logic [1:0] a, int s, int pe);
    cmd_item_t c;
    c.action = a; c.symbol = SYM_W'(s); c.pattern_end = (pe != 0); c.drain = 0;
    pending_cmds.push_back(c);
  endfunction

  function automatic void add_drain();
    cmd_item_t c;
    c.action = ACT_APPEND; c.symbol = 0; c.pattern_end = 0; c.drain = 1;
    pending_cmds.push_back(c);
  endfunction

  // generator's view of the text, used to build patterns that match
  int gen_text[$];

  function automatic void add_append(int s);
    add_cmd(ACT_APPEND, s, 0);
    if (s < ALPHABET && gen_text.size() < MAX_TEXT) gen_text.push_back(s);
  endfunction

  function automatic void add_clear();
    add_cmd(ACT_CLEAR, $urandom_range(0, 31), $urandom_range(0, 1));
    gen_text.delete();
  endfunction

  function automatic void add_pattern(bit spoil);
    int b, n, bad;
    if (gen_text.size() == 0) begin
      add_cmd(ACT_QUERY, $urandom_range(0, 31), 1);
      return;
    end
    n = $urandom_range(1, (gen_text.size() < 12) ? gen_text.size() : 12);
    b = $urandom_range(0, gen_text.size() - n);
    bad = spoil ? $urandom_range(0, n - 1) : -1;
    for (int k = 0; k < n; k++)
      add_cmd(ACT_QUERY, (k == bad) ? $urandom_range(0, 31) : gen_text[b+k], k == n - 1);
  endfunction

  initial begin
    int kind, sym_span;
    bit drained;
    drained = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty queries, extremes, out-of-alphabet, unused action, clear
    add_cmd(ACT_QUERY, 0, 1);
    add_append(0);
    add_append(25);
    add_append(31);
    add_append(0);
    add_append(25);
    add_append(0);
    add_cmd(ACT_QUERY, 25, 0);
    add_cmd(ACT_QUERY, 0, 1);
    add_cmd(ACT_QUERY, 0, 0);
    add_cmd(ACT_QUERY, 26, 0);
    add_cmd(ACT_QUERY, 0, 1);
    add_cmd(ACT_QUERY, 1, 1);
    add_cmd(ACT_QUERY, 0, 0);
    add_cmd(ACT_UNUSED, 31, 1);
    add_cmd(ACT_QUERY, 25, 0);
    add_cmd(ACT_APPEND, 1, 1);
    add_cmd(ACT_QUERY, 0, 1);
    add_clear();
    add_cmd(ACT_QUERY, 0, 1);
    add_append(2);
    add_drain();

    // random: mostly text runs and real substrings, some noise
    while (pending_cmds.size() < 1400) begin
      kind = $urandom_range(0, 99);
      sym_span = ($urandom_range(0, 3) == 0) ? 31 : $urandom_range(1, 4);
      if (kind < 3) add_clear();
      else if (kind < 45) add_append($urandom_range(0, sym_span));
      else if (kind < 75) add_pattern(0);
      else if (kind < 85) add_pattern(1);
      else if (kind < 90) add_cmd(ACT_UNUSED, $urandom_range(0, 31), $urandom_range(0, 1));
      else add_cmd(ACT_QUERY, $urandom_range(0, 31), $urandom_range(0, 1));
      if (!drained && pending_cmds.size() >= 700) begin
        add_drain();
        drained = 1;
      end
    end

    wait (pending_cmds.size() == 0);
    @(posedge clk);
    while (start || expected_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("[suffix_automaton_builder_unit] OK");
    end else begin
      $display("[suffix_automaton_builder_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("[suffix_automaton_builder_unit] ERROR");
    $finish;
  end

  initial reset_automaton();

endmodule

/* suffix_automaton_builder_unit.f */
design/sa_pkg.sv
design/sa_ram.sv
design/sa_ctrl.sv
design/sa_dpath.sv
design/suffix_automaton_builder_unit.sv
tb/sv/tb_top.sv
